@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define CHK_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error("check failed");
`define CHK_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error("check failed");
`else
`define CHK_IMP(lbl, clk, rst, a, c)
`define CHK_NEXT(lbl, clk, rst, a, c)
`endif
`endif

@@ src/sfcr_pkg.sv @@
// Package: constants and types for the symbol histogram and ranker
package sfcr_pkg;
  localparam int ALPHABET_SIZE = 256;
  localparam int COUNT_BITS = 16;
  localparam int SYM_BITS = 8;
  localparam int DIST_BITS = 9;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CLR, ST_INC_RD, ST_INC_WR, ST_S_RD, ST_S_CHK, ST_T_RD, ST_T_CMP,
    ST_S_WR, ST_Q_RD, ST_Q_HRD, ST_Q_OUT
  } state_t;
endpackage

@@ src/sfcr_hist.sv @@
// Histogram memory: one read port with registered data, one write port
module sfcr_hist (
  input  logic clk,
  input  logic we,
  input  logic [sfcr_pkg::SYM_BITS-1:0] waddr,
  input  logic [sfcr_pkg::COUNT_BITS-1:0] wdata,
  input  logic [sfcr_pkg::SYM_BITS-1:0] raddr,
  output logic [sfcr_pkg::COUNT_BITS-1:0] rdata
);
  import sfcr_pkg::*;
  logic [COUNT_BITS-1:0] mem [ALPHABET_SIZE];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/sfcr_order.sv @@
// Sorted order memory: symbols indexed by rank
module sfcr_order (
  input  logic clk,
  input  logic we,
  input  logic [sfcr_pkg::SYM_BITS-1:0] waddr,
  input  logic [sfcr_pkg::SYM_BITS-1:0] wdata,
  input  logic [sfcr_pkg::SYM_BITS-1:0] raddr,
  output logic [sfcr_pkg::SYM_BITS-1:0] rdata
);
  import sfcr_pkg::*;
  logic [SYM_BITS-1:0] mem [ALPHABET_SIZE];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ src/symbol_frequency_count_and_rank_top.sv @@
// Top level: byte histogram with on-demand ascending-frequency ranking
`include "assert_macros.svh"
// A word is taken when start is high and busy is low; for a count, clear
// or query busy then stays high until the command is done. Count: read,
// then write back the saturated count, over the one histogram memory
// port pair. Clear: one entry zeroed a cycle. Query when the order is
// current: order read, histogram read, result. After any count or clear
// the order is first rebuilt: each symbol is read and looked at, and for
// each present one the whole histogram is swept through one shared
// compare (a read and a compare per entry) before its rank is written.
// After reset a clearing pass runs with busy high. The result shows on
// the result ports with valid high for one cycle only; the receiver
// cannot stall it, so it must take it then.
module symbol_frequency_count_and_rank_top (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic [1:0] command,
  input  logic [7:0] symbol,
  input  logic [7:0] rank,
  output logic valid,
  output logic [7:0] ranked_symbol,
  output logic [15:0] symbol_count,
  output logic found,
  output logic [8:0] distinct_symbols
);
  import sfcr_pkg::*;

  state_t state, state_next;
  logic [SYM_BITS:0] idx, idx_next;        // sweep counter (clear, outer s)
  logic [SYM_BITS:0] tix, tix_next;        // inner sweep counter
  logic [SYM_BITS-1:0] pos, pos_next;      // rank being accumulated
  logic [COUNT_BITS-1:0] hs, hs_next;      // count of the outer symbol
  logic [DIST_BITS-1:0] n_present, n_present_next, ndist, ndist_next;
  logic order_ok, order_ok_next;
  logic [SYM_BITS-1:0] sym_r, rk_r, qsym, qsym_next;

  logic h_we, o_we;
  logic [SYM_BITS-1:0] h_wa, h_ra, o_wa, o_wd, o_ra;
  logic [COUNT_BITS-1:0] h_wd, h_rd;
  logic [SYM_BITS-1:0] o_rd;
  logic tcmp_less;

  sfcr_hist u_hist (.clk, .we(h_we), .waddr(h_wa), .wdata(h_wd), .raddr(h_ra), .rdata(h_rd));
  sfcr_order u_order (.clk, .we(o_we), .waddr(o_wa), .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));

  // shared comparator: does entry t come before the outer symbol?
  assign tcmp_less = (h_rd != '0) && (tix[SYM_BITS-1:0] != idx[SYM_BITS-1:0]) &&
                     ((h_rd < hs) || ((h_rd == hs) && (tix[SYM_BITS-1:0] < idx[SYM_BITS-1:0])));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLR;
      idx <= '0;
      order_ok <= 1'b0;
      n_present <= '0;
    end else begin
      state <= state_next;
      idx <= idx_next;
      order_ok <= order_ok_next;
      n_present <= n_present_next;
    end
    tix <= tix_next;
    pos <= pos_next;
    hs <= hs_next;
    ndist <= ndist_next;
    qsym <= qsym_next;
    if (start && !busy) begin
      sym_r <= symbol;
      rk_r <= rank;
    end
  end

  always_comb begin
    state_next = state;
    idx_next = idx;
    tix_next = tix;
    pos_next = pos;
    hs_next = hs;
    n_present_next = n_present;
    ndist_next = ndist;
    order_ok_next = order_ok;
    qsym_next = qsym;
    busy = (state != ST_IDLE);
    h_we = 1'b0;
    h_wa = idx[SYM_BITS-1:0];
    h_wd = '0;
    h_ra = sym_r;
    o_we = 1'b0;
    o_wa = pos;
    o_wd = idx[SYM_BITS-1:0];
    o_ra = rk_r;
    valid = 1'b0;
    ranked_symbol = '0;
    symbol_count = '0;
    found = 1'b0;
    distinct_symbols = n_present;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd_t'(command))
            CMD_COUNT: state_next = ST_INC_RD;
            CMD_CLEAR: begin
              idx_next = '0;
              state_next = ST_CLR;
            end
            CMD_QUERY: begin
              if (order_ok) state_next = ST_Q_RD;
              else begin
                idx_next = '0;
                ndist_next = '0;
                state_next = ST_S_RD;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_CLR: begin
        h_we = 1'b1;
        order_ok_next = 1'b0;
        idx_next = idx + 1'b1;
        if (idx[SYM_BITS-1:0] == SYM_BITS'(ALPHABET_SIZE - 1)) state_next = ST_IDLE;
      end
      ST_INC_RD: state_next = ST_INC_WR;
      ST_INC_WR: begin
        h_we = 1'b1;
        h_wa = sym_r;
        h_wd = (h_rd == CNT_MAX) ? h_rd : h_rd + 1'b1;
        order_ok_next = 1'b0;
        state_next = ST_IDLE;
      end
      ST_S_RD: begin
        h_ra = idx[SYM_BITS-1:0];
        state_next = ST_S_CHK;
      end
      ST_S_CHK: begin
        hs_next = h_rd;
        pos_next = '0;
        tix_next = '0;
        if (h_rd != '0) begin
          ndist_next = ndist + 1'b1;
          state_next = ST_T_RD;
        end else begin
          idx_next = idx + 1'b1;
          if (idx[SYM_BITS-1:0] == SYM_BITS'(ALPHABET_SIZE - 1)) begin
            n_present_next = ndist;
            order_ok_next = 1'b1;
            state_next = ST_Q_RD;
          end else state_next = ST_S_RD;
        end
      end
      ST_T_RD: begin
        h_ra = tix[SYM_BITS-1:0];
        state_next = ST_T_CMP;
      end
      ST_T_CMP: begin
        if (tcmp_less) pos_next = pos + 1'b1;
        tix_next = tix + 1'b1;
        if (tix[SYM_BITS-1:0] == SYM_BITS'(ALPHABET_SIZE - 1)) state_next = ST_S_WR;
        else state_next = ST_T_RD;
      end
      ST_S_WR: begin
        o_we = 1'b1;
        idx_next = idx + 1'b1;
        if (idx[SYM_BITS-1:0] == SYM_BITS'(ALPHABET_SIZE - 1)) begin
          n_present_next = ndist;
          order_ok_next = 1'b1;
          state_next = ST_Q_RD;
        end else state_next = ST_S_RD;
      end
      ST_Q_RD: state_next = ST_Q_HRD;
      ST_Q_HRD: begin
        qsym_next = o_rd;
        h_ra = o_rd;
        state_next = ST_Q_OUT;
      end
      ST_Q_OUT: begin
        valid = 1'b1;
        found = ({1'b0, rk_r} < n_present);
        if (found) begin
          ranked_symbol = qsym;
          symbol_count = h_rd;
        end
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `CHK_IMP(a_valid_busy, clk, rst, valid, busy)
  `CHK_NEXT(a_valid_one, clk, rst, valid, !valid)
  `CHK_IMP(a_found_present, clk, rst, valid && found, n_present != '0)
  `CHK_NEXT(a_count_clears_ok, clk, rst, state == ST_INC_WR, !order_ok)
endmodule

@@ tb/testbench.sv @@
// Testbench for the byte histogram and ascending-frequency ranker
`timescale 1ns / 1ps
module testbench;
  import sfcr_pkg::*;

  // Expected answer to one rank query
  typedef struct {
    logic [7:0]  sym;
    logic [15:0] cnt;
    logic        hit;
    logic [8:0]  n_distinct;
  } rank_answer_t;

  localparam int STALL_LIMIT = 600000;  // bound for a rebuild over all 256 symbols
  localparam int SETTLE      = 300;     // covers a clear pass still in flight

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  command = CMD_NONE;
  logic [7:0]  symbol = '0;
  logic [7:0]  rank = '0;
  logic        valid;
  logic [7:0]  ranked_symbol;
  logic [15:0] symbol_count;
  logic        found;
  logic [8:0]  distinct_symbols;

  // Predictor state
  logic [15:0] freq [ALPHABET_SIZE];
  logic [7:0]  order_by_freq [ALPHABET_SIZE];
  logic        order_valid;
  logic [8:0]  present_total;

  rank_answer_t pending_answers [$];
  int  fail_count = 0;
  int  words_sent = 0;
  bit  gaps_on = 1'b1;
  int  quiet_cycles = 0;

  symbol_frequency_count_and_rank_top DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .command(command), .symbol(symbol), .rank(rank),
    .valid(valid), .ranked_symbol(ranked_symbol), .symbol_count(symbol_count),
    .found(found), .distinct_symbols(distinct_symbols)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Position of each present symbol: count of present symbols that sort ahead of it
  task automatic sort_by_freq();
    int ahead;
    present_total = '0;
    for (int s = 0; s < ALPHABET_SIZE; s++) begin
      if (freq[s] != 0) begin
        ahead = 0;
        for (int t = 0; t < ALPHABET_SIZE; t++) begin
          if (freq[t] != 0 && t != s &&
              (freq[t] < freq[s] || (freq[t] == freq[s] && t < s)))
            ahead++;
        end
        order_by_freq[ahead] = s[7:0];
        present_total++;
      end
    end
    order_valid = 1'b1;
  endtask

  task automatic predict_word(cmd_t c, logic [7:0] s, logic [7:0] r);
    rank_answer_t a;
    case (c)
      CMD_COUNT: begin
        if (freq[s] != CNT_MAX) freq[s]++;
        order_valid = 1'b0;
      end
      CMD_CLEAR: begin
        foreach (freq[i]) freq[i] = '0;
        order_valid = 1'b0;
      end
      CMD_QUERY: begin
        if (!order_valid) sort_by_freq();
        if (r < present_total) begin
          a.sym = order_by_freq[r];
          a.cnt = freq[order_by_freq[r]];
          a.hit = 1'b1;
        end else begin
          a.sym = '0;
          a.cnt = '0;
          a.hit = 1'b0;
        end
        a.n_distinct = present_total;
        pending_answers.push_back(a);
      end
      default: ;
    endcase
  endtask

  // Drive one word at the falling edge; start stays high until the caller idles or a random gap drops it
  task automatic send_word(cmd_t c, logic [7:0] s, logic [7:0] r);
    @(negedge clk);
    start   = 1'b1;
    command = c;
    symbol  = s;
    rank    = r;
    do @(posedge clk); while (busy);
    predict_word(c, s, r);
    words_sent++;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
  endtask

  task automatic go_quiet();
    @(negedge clk);
    start = 1'b0;
  endtask

  // Sender holds off until every answer is back
  task automatic drain();
    go_quiet();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Answer checker: a result lasts one cycle only
  always @(posedge clk) begin
    rank_answer_t e;
    if (!rst && valid) begin
      if (pending_answers.size() == 0) begin
        $error("unexpected result: symbol %0d count %0d", ranked_symbol, symbol_count);
        fail_count++;
      end else begin
        e = pending_answers.pop_front();
        if (ranked_symbol !== e.sym) begin
          $error("ranked_symbol: expected %0d, got %0d", e.sym, ranked_symbol);
          fail_count++;
        end
        if (symbol_count !== e.cnt) begin
          $error("symbol_count: expected %0d, got %0d", e.cnt, symbol_count);
          fail_count++;
        end
        if (found !== e.hit) begin
          $error("found: expected %0d, got %0d", e.hit, found);
          fail_count++;
        end
        if (distinct_symbols !== e.n_distinct) begin
          $error("distinct_symbols: expected %0d, got %0d", e.n_distinct, distinct_symbols);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: cycles with neither a word taken nor a result given
  always @(posedge clk) begin
    if (rst || (start && !busy) || valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("symbol_frequency_count_and_rank_top test failed");
      $finish;
    end
  end

  // Empty table, extremes of symbol and rank, a tie, the unused command
  task automatic test_directed();
    send_word(CMD_QUERY, 8'd0, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd255);
    send_word(CMD_COUNT, 8'd255, 8'd0);
    send_word(CMD_COUNT, 8'd0, 8'd0);
    send_word(CMD_COUNT, 8'h55, 8'd0);
    send_word(CMD_COUNT, 8'hAA, 8'd0);
    send_word(CMD_COUNT, 8'hAA, 8'd0);
    send_word(CMD_NONE, 8'hAA, 8'd0);
    send_word(CMD_NONE, 8'hFF, 8'hFF);
    for (int r = 0; r < 5; r++) send_word(CMD_QUERY, 8'h00, r[7:0]);
    send_word(CMD_QUERY, 8'hFF, 8'd255);
    send_word(CMD_CLEAR, 8'd0, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd0);
    send_word(CMD_COUNT, 8'h81, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd0);
    drain();
  endtask

  // Every symbol present once, a few more often; one full-size rebuild
  task automatic test_full_alphabet();
    send_word(CMD_CLEAR, 8'd0, 8'd0);
    for (int s = 0; s < ALPHABET_SIZE; s++) send_word(CMD_COUNT, s[7:0], 8'd0);
    send_word(CMD_COUNT, 8'd7, 8'd0);
    send_word(CMD_COUNT, 8'd200, 8'd0);
    send_word(CMD_COUNT, 8'd7, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd0);
    send_word(CMD_QUERY, 8'd0, 8'd255);
    send_word(CMD_QUERY, 8'd0, 8'd254);
    send_word(CMD_QUERY, 8'd0, 8'd128);
    drain();
  endtask

  // Random phases: clear, counts over a small pool, then queries; some noise
  task automatic test_random();
    logic [7:0] pool [8];
    int pool_n;
    int phase = 0;
    int base = words_sent;
    while (words_sent - base < 1470) begin
      gaps_on = (words_sent - base < 1170) && ($urandom_range(0, 2) != 0);
      if ($urandom_range(0, 3) != 0) send_word(CMD_CLEAR, 8'($urandom), 8'($urandom));
      pool_n = $urandom_range(1, 6);
      foreach (pool[i]) pool[i] = 8'($urandom);
      repeat ($urandom_range(5, 30)) begin
        if ($urandom_range(0, 15) == 0) send_word(CMD_NONE, 8'($urandom), 8'($urandom));
        else send_word(CMD_COUNT, pool[$urandom_range(0, pool_n - 1)], 8'($urandom));
      end
      repeat ($urandom_range(2, 8)) begin
        if ($urandom_range(0, 9) == 0)
          send_word(CMD_COUNT, pool[$urandom_range(0, pool_n - 1)], 8'($urandom));
        else if ($urandom_range(0, 7) == 0)
          send_word(CMD_QUERY, 8'($urandom), 8'($urandom));
        else
          send_word(CMD_QUERY, 8'($urandom), 8'($urandom_range(0, pool_n + 1)));
      end
      phase++;
      if (phase % 10 == 0 && words_sent - base < 1170) drain();
    end
    go_quiet();
  endtask

  initial begin
    foreach (freq[i]) freq[i] = '0;
    foreach (order_by_freq[i]) order_by_freq[i] = '0;
    order_valid   = 1'b0;
    present_total = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_full_alphabet();
    test_random();
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0) begin
      $display("symbol_frequency_count_and_rank_top test passed");
    end else begin
      $display("symbol_frequency_count_and_rank_top test failed");
    end
    $finish;
  end
endmodule
